[sv/difficulty_to_target_divider_unit_macros.svh]
// Assertion macros shared by the divider unit checker
`ifndef DIFFICULTY_TO_TARGET_DIVIDER_UNIT_MACROS_SVH
`define DIFFICULTY_TO_TARGET_DIVIDER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define DTTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("divider unit check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define DTTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("divider unit check failed");

`endif

[sv/dttd_pkg.sv]
// Package with types and constants of the difficulty to target divider unit
`default_nettype none

package dttd_pkg;

	// Field widths
	localparam int WORD_W   = 64;
	localparam int FRAC_W   = 52;
	localparam int EXP_W    = 11;
	localparam int MANT_W   = FRAC_W + 1;
	localparam int TGT_W    = 4 * WORD_W;

	// Division span and step counter
	localparam int WIDE_BITS = 384;
	localparam int STEP_W    = $clog2(WIDE_BITS);
	localparam int POS_W     = 12;

	// Position of the lowest set bit of the difficulty-1 target for a given
	// exponent: 208 + 1075 - exponent field
	localparam logic [EXP_W-1:0]        EXP_SPECIAL = {EXP_W{1'b1}};
	localparam logic signed [POS_W-1:0] POS_BIAS    = 12'sd1283;
	// Highest legal low-bit position: left shift of 160
	localparam logic signed [POS_W-1:0] POS_MAX     = 12'sd368;
	// The difficulty-1 target holds sixteen ones above its low bit
	localparam logic signed [POS_W-1:0] T1_SPAN_M1  = 12'sd15;

	localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(WIDE_BITS - 1);
	localparam logic [STEP_W-1:0] STEP_OVF = STEP_W'(TGT_W);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

endpackage

`default_nettype wire

[sv/difficulty_to_target_divider_unit.sv]
// Difficulty to 256-bit share target: double decode and bit-serial divider
//
//   channel   direction  handshake        payload
//   command   in         start / busy     difficulty_bits
//   result    out        done (strobe)    target_word3..0, saturated, status
//
// A command is taken when start is high and busy is low. A NaN, infinity,
// zero, negative or out-of-range difficulty is answered in the next cycle.
// A valid one runs the restoring divider one quotient bit per cycle over
// 384 bits; busy holds until the last quotient bit is in, and done rises
// in the same cycle as busy falls.
// done is high for one cycle and cannot be held off; a new command may be
// taken in that same cycle. arst_n clears the sequencer at once.
`default_nettype none

module difficulty_to_target_divider_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [dttd_pkg::WORD_W-1:0]    difficulty_bits,
	output logic                          busy,
	output logic                          done,
	output logic [dttd_pkg::WORD_W-1:0]   target_word3,
	output logic [dttd_pkg::WORD_W-1:0]   target_word2,
	output logic [dttd_pkg::WORD_W-1:0]   target_word1,
	output logic [dttd_pkg::WORD_W-1:0]   target_word0,
	output logic                          saturated,
	output logic                          status
);
	import dttd_pkg::*;

	state_t state_q, state_d;

	logic                     done_q;
	logic                     sat_q;
	logic                     status_q;
	logic                     ovf_q;
	logic [MANT_W-1:0]        mant_q;
	logic [MANT_W-1:0]        rem_q;
	logic [TGT_W-1:0]         quo_q;
	logic signed [POS_W-1:0]  pos_q;
	logic [STEP_W-1:0]        step_q;

	// Decode of the incoming double
	logic                     in_sign;
	logic [EXP_W-1:0]         in_exp;
	logic [FRAC_W-1:0]        in_frac;
	logic                     in_invalid;
	logic                     in_sub;
	logic signed [POS_W-1:0]  in_pos;
	logic                     accept;

	// One divider step
	logic signed [POS_W-1:0]  step_pos;
	logic                     num_bit;
	logic [MANT_W:0]          trial;
	logic [MANT_W:0]          diff;
	logic                     q_bit;

	assign in_sign    = difficulty_bits[WORD_W-1];
	assign in_exp     = difficulty_bits[WORD_W-2 -: EXP_W];
	assign in_frac    = difficulty_bits[FRAC_W-1:0];
	assign in_invalid = in_sign || (in_exp == EXP_SPECIAL) ||
	                    ((in_exp == '0) && (in_frac == '0));
	assign in_sub     = (in_exp == '0);
	assign in_pos     = POS_BIAS - $signed({1'b0, in_exp});
	assign accept     = start && !busy;

	// Numerator bit: inside the sixteen-bit run of the shifted target
	assign step_pos = $signed({{(POS_W-STEP_W){1'b0}}, step_q});
	assign num_bit  = (step_pos >= pos_q) && (step_pos <= pos_q + T1_SPAN_M1);
	assign trial    = {rem_q, num_bit};
	assign diff     = trial - {1'b0, mant_q};
	assign q_bit    = !diff[MANT_W];

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake; busy is low in idle, so start alone takes a command
	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && !in_invalid && !in_sub && (in_pos <= POS_MAX)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				busy = 1'b1;
				if (step_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Flag the result transfer and its status bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			sat_q    <= 1'b0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				if (in_invalid) begin
					done_q   <= 1'b1;
					status_q <= 1'b1;
					sat_q    <= 1'b0;
				end else if (in_sub || (in_pos > POS_MAX)) begin
					done_q   <= 1'b1;
					status_q <= 1'b0;
					sat_q    <= 1'b1;
				end else begin
					status_q <= 1'b0;
					sat_q    <= 1'b0;
				end
			end else if ((state_q == ST_DIV) && (step_q == '0)) begin
				done_q <= 1'b1;
				sat_q  <= ovf_q;
			end
		end
	end

	// Load operands on accept, then advance one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			mant_q <= {1'b1, in_frac};
			pos_q  <= in_pos;
			step_q <= STEP_TOP;
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (state_q == ST_DIV) begin
			rem_q  <= q_bit ? diff[MANT_W-1:0] : trial[MANT_W-1:0];
			quo_q  <= {quo_q[TGT_W-2:0], q_bit};
			step_q <= step_q - 1'b1;
			if (q_bit && (step_q >= STEP_OVF)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Drive the result; saturation forces all ones
	assign done         = done_q;
	assign saturated    = sat_q;
	assign status       = status_q;
	assign target_word3 = sat_q ? '1 : quo_q[4*WORD_W-1 -: WORD_W];
	assign target_word2 = sat_q ? '1 : quo_q[3*WORD_W-1 -: WORD_W];
	assign target_word1 = sat_q ? '1 : quo_q[2*WORD_W-1 -: WORD_W];
	assign target_word0 = sat_q ? '1 : quo_q[WORD_W-1:0];

endmodule

`default_nettype wire

[sv/dttd_checker.sv]
// Port-level checker for the divider unit, bound to the divider unit module
`default_nettype none

`include "difficulty_to_target_divider_unit_macros.svh"

module dttd_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         start,
	input wire                         busy,
	input wire                         done,
	input wire [dttd_pkg::WORD_W-1:0]  target_word3,
	input wire [dttd_pkg::WORD_W-1:0]  target_word2,
	input wire [dttd_pkg::WORD_W-1:0]  target_word1,
	input wire [dttd_pkg::WORD_W-1:0]  target_word0,
	input wire                         saturated,
	input wire                         status
);
	import dttd_pkg::*;

	// A result transfer only comes once the unit is free again
	`DTTD_ASSERT_NOW(a_done_idle, done, !busy)

	// An accepted command either keeps the unit busy or answers at once
	`DTTD_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)

	// Invalid difficulty gives a zero target, never saturation
	`DTTD_ASSERT_NOW(a_invalid_zero, done && status,
		!saturated && (target_word3 == '0) && (target_word2 == '0) &&
		(target_word1 == '0) && (target_word0 == '0))

	// Saturation means a valid difficulty and an all-ones target
	`DTTD_ASSERT_NOW(a_sat_ones, done && saturated,
		!status && (&target_word3) && (&target_word2) &&
		(&target_word1) && (&target_word0))

endmodule

bind difficulty_to_target_divider_unit dttd_checker u_dttd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.target_word3 (target_word3),
	.target_word2 (target_word2),
	.target_word1 (target_word1),
	.target_word0 (target_word0),
	.saturated    (saturated),
	.status       (status)
);

`default_nettype wire
